FILE: rtl/core/cfp_pkg.sv
package cfp_pkg;

  // register indexes on the configuration port
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_HEADER_FIRST  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_HEADER_SECOND = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_TAIL_VALUE    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_MAX_LENGTH    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT_TICKS = 3'd4;
  localparam int unsigned CfgDataW = 32;

  // register reset values
  localparam logic [7:0]  HEADER_FIRST_RST  = 8'hAA;
  localparam logic [7:0]  HEADER_SECOND_RST = 8'h55;
  localparam logic [7:0]  TAIL_VALUE_RST    = 8'h0D;
  localparam logic [15:0] MAX_LENGTH_RST    = 16'd1024;
  localparam logic [31:0] TIMEOUT_TICKS_RST = 32'd100;

  // crc16-ccitt (false variant)
  localparam logic [15:0] CRC_SEED   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam logic [15:0] CRC_TOPBIT = 16'h8000;

  // item kinds
  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef enum logic [1:0] {
    STATUS_BUSY     = 2'd0,
    STATUS_GOOD     = 2'd1,
    STATUS_TOO_LONG = 2'd2,
    STATUS_BAD      = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    PH_HUNT1   = 4'd0,
    PH_HUNT2   = 4'd1,
    PH_CMD     = 4'd2,
    PH_LENH    = 4'd3,
    PH_LENL    = 4'd4,
    PH_PAYLOAD = 4'd5,
    PH_CRCH    = 4'd6,
    PH_CRCL    = 4'd7,
    PH_TAIL    = 4'd8
  } phase_t;

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  frame_cmd;
    logic [15:0] frame_len;
    logic [7:0]  payload_byte;
    logic        payload_strobe;
    logic [15:0] payload_index;
    logic [31:0] frames_good;
    logic [31:0] frames_bad;
    logic        timed_out;
  } out_t;

  typedef struct packed {
    logic [7:0]  header_first;
    logic [7:0]  header_second;
    logic [7:0]  tail_value;
    logic [15:0] max_length;
    logic [31:0] timeout_ticks;
  } cfg_t;

  // one byte through the crc, msb first
  function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOPBIT) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/core/cfp_cfg_regs.sv
module cfp_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [cfp_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [cfp_pkg::CfgDataW-1:0]    cfg_wdata,
  output cfp_pkg::cfg_t                   cfg
);

  cfp_pkg::cfg_t cfg_r;
  cfp_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        cfp_pkg::CFG_HEADER_FIRST:  cfg_nxt.header_first  = cfg_wdata[7:0];
        cfp_pkg::CFG_HEADER_SECOND: cfg_nxt.header_second = cfg_wdata[7:0];
        cfp_pkg::CFG_TAIL_VALUE:    cfg_nxt.tail_value    = cfg_wdata[7:0];
        cfp_pkg::CFG_MAX_LENGTH:    cfg_nxt.max_length    = cfg_wdata[15:0];
        cfp_pkg::CFG_TIMEOUT_TICKS: cfg_nxt.timeout_ticks = cfg_wdata[31:0];
        default: ;  // unknown index, ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_first  <= cfp_pkg::HEADER_FIRST_RST;
      cfg_r.header_second <= cfp_pkg::HEADER_SECOND_RST;
      cfg_r.tail_value    <= cfp_pkg::TAIL_VALUE_RST;
      cfg_r.max_length    <= cfp_pkg::MAX_LENGTH_RST;
      cfg_r.timeout_ticks <= cfp_pkg::TIMEOUT_TICKS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/core/crc_framed_packet_parser.sv
// byte-framed packet parser with crc16-ccitt check. each input transaction is
// either a received byte or one time tick, and each produces exactly one result
// transaction, registered in the single output register. a new input
// transaction is taken in every cycle as long as the output register is empty
// or being drained in the same cycle, so the sustained rate is one transaction
// per clock; the only thing that holds the input is a stalled, full output
// register. frames are: header_first, header_second, command, length (msb
// first), payload, crc (msb first), tail. the crc (poly 0x1021, seed 0xffff)
// covers header_second through the last payload byte and is updated with one
// byte of unrolled xor logic per cycle in which a byte is accepted. configuration
// registers may only be written while no transaction is in flight.
module crc_framed_packet_parser (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  cfp_pkg::in_t                    in_data,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output cfp_pkg::out_t                   out_data,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [cfp_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [cfp_pkg::CfgDataW-1:0]    cfg_wdata
);

  cfp_pkg::cfg_t cfg;

  cfp_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // parser state
  cfp_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] pcount_r, pcount_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] crc_rx_r, crc_rx_nxt;
  logic [31:0] idle_r, idle_nxt;
  logic [31:0] good_r, good_nxt;
  logic [31:0] bad_r, bad_nxt;

  // output register
  logic          out_valid_r, out_valid_nxt;
  cfp_pkg::out_t out_data_r, out_data_nxt;

  logic        in_accept;
  logic [7:0]  b;
  logic [15:0] crc_upd;
  logic [15:0] len_full;
  logic [15:0] pcount_inc;
  cfp_pkg::status_t status;

  // hold the input only when the result register is full and not draining
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  assign b          = in_data.data_byte;
  assign len_full   = {len_r[15:8], b};
  assign pcount_inc = pcount_r + 16'd1;

  // the running crc update for each byte; in the second header phase it starts from the seed
  always_comb begin
    if (phase_r == cfp_pkg::PH_HUNT2) begin
      crc_upd = cfp_pkg::crc_step(cfp_pkg::CRC_SEED, b);
    end else begin
      crc_upd = cfp_pkg::crc_step(crc_r, b);
    end
  end

  // next state and result of one transaction
  always_comb begin
    phase_nxt  = phase_r;
    cmd_nxt    = cmd_r;
    len_nxt    = len_r;
    pcount_nxt = pcount_r;
    crc_nxt    = crc_r;
    crc_rx_nxt = crc_rx_r;
    idle_nxt   = idle_r;
    good_nxt   = good_r;
    bad_nxt    = bad_r;
    status     = cfp_pkg::STATUS_BUSY;

    out_data_nxt                = '0;

    if (in_data.func == cfp_pkg::FUNC_TICK) begin
      // idle time, saturating
      if (idle_r != '1) begin
        idle_nxt = idle_r + 32'd1;
      end
    end else begin
      idle_nxt = '0;
      case (phase_r)
        cfp_pkg::PH_HUNT2: begin
          // a wrong second header drops back to the hunt, no error
          if (b == cfg.header_second) begin
            crc_nxt   = crc_upd;
            phase_nxt = cfp_pkg::PH_CMD;
          end else begin
            phase_nxt = cfp_pkg::PH_HUNT1;
          end
        end
        cfp_pkg::PH_CMD: begin
          cmd_nxt   = b;
          crc_nxt   = crc_upd;
          phase_nxt = cfp_pkg::PH_LENH;
        end
        cfp_pkg::PH_LENH: begin
          len_nxt   = {b, 8'h00};
          crc_nxt   = crc_upd;
          phase_nxt = cfp_pkg::PH_LENL;
        end
        cfp_pkg::PH_LENL: begin
          len_nxt = len_full;
          crc_nxt = crc_upd;
          if (len_full > cfg.max_length) begin
            // oversize frame is rejected right here
            phase_nxt = cfp_pkg::PH_HUNT1;
            bad_nxt   = bad_r + 32'd1;
            status    = cfp_pkg::STATUS_TOO_LONG;
          end else begin
            pcount_nxt = '0;
            phase_nxt  = (len_full == 16'd0) ? cfp_pkg::PH_CRCH : cfp_pkg::PH_PAYLOAD;
          end
        end
        cfp_pkg::PH_PAYLOAD: begin
          // payload bytes stream out as they arrive
          out_data_nxt.payload_byte   = b;
          out_data_nxt.payload_strobe = 1'b1;
          out_data_nxt.payload_index  = pcount_r;
          pcount_nxt = pcount_inc;
          crc_nxt    = crc_upd;
          if (pcount_inc >= len_r) begin
            phase_nxt = cfp_pkg::PH_CRCH;
          end
        end
        cfp_pkg::PH_CRCH: begin
          crc_rx_nxt = {b, 8'h00};
          phase_nxt  = cfp_pkg::PH_CRCL;
        end
        cfp_pkg::PH_CRCL: begin
          crc_rx_nxt = {crc_rx_r[15:8], b};
          phase_nxt  = cfp_pkg::PH_TAIL;
        end
        cfp_pkg::PH_TAIL: begin
          // any byte closes the frame; good only with matching tail and crc
          phase_nxt = cfp_pkg::PH_HUNT1;
          if (b == cfg.tail_value && crc_r == crc_rx_r) begin
            good_nxt = good_r + 32'd1;
            status   = cfp_pkg::STATUS_GOOD;
          end else begin
            bad_nxt = bad_r + 32'd1;
            status  = cfp_pkg::STATUS_BAD;
          end
        end
        default: begin
          // first header hunt, also catches unused phase codes
          phase_nxt = (b == cfg.header_first) ? cfp_pkg::PH_HUNT2 : cfp_pkg::PH_HUNT1;
        end
      endcase
    end

    out_data_nxt.status      = status;
    out_data_nxt.frame_cmd   = cmd_nxt;
    out_data_nxt.frame_len   = len_nxt;
    out_data_nxt.frames_good = good_nxt;
    out_data_nxt.frames_bad  = bad_nxt;
    out_data_nxt.timed_out   = (phase_nxt != cfp_pkg::PH_HUNT1) &&
                               (idle_nxt > cfg.timeout_ticks);
  end

  // result register fills on accept and empties when taken
  always_comb begin
    if (in_accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= cfp_pkg::PH_HUNT1;
      cmd_r       <= '0;
      len_r       <= '0;
      pcount_r    <= '0;
      crc_r       <= '0;
      crc_rx_r    <= '0;
      idle_r      <= '0;
      good_r      <= '0;
      bad_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_accept) begin
        phase_r  <= phase_nxt;
        cmd_r    <= cmd_nxt;
        len_r    <= len_nxt;
        pcount_r <= pcount_nxt;
        crc_r    <= crc_nxt;
        crc_rx_r <= crc_rx_nxt;
        idle_r   <= idle_nxt;
        good_r   <= good_nxt;
        bad_r    <= bad_nxt;
      end
    end
  end

  // payload of the result register, no reset needed
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
